/* rtl/core/oscg_pkg.sv */
// oscg_pkg: shared constants and types for the output short-circuit guard.
// No dependencies; used by output_short_circuit_guard.
`timescale 1ns / 1ps

package oscg_pkg;

    // Field widths
    localparam int DEB_W    = 6;
    localparam int REC_W    = 4;
    localparam int PER_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IX_W = 2;
    localparam int TDATA_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_DEBOUNCE_SAMPLES   = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_RECOVERY_PERIODS   = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_FLASH_PERIOD_TICKS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 6'd21;
    localparam logic [REC_W-1:0] RECOVERY_RESET = 4'd5;
    localparam logic [PER_W-1:0] PERIOD_RESET   = 16'd4000;

    // Run counters saturate here
    localparam logic [DEB_W-1:0] RUN_MAX = 6'd63;

    // One result transaction
    typedef struct packed {
        logic short_active;
        logic complement_pin;
        logic low_side_on;
        logic led_on;
    } result_t;

endpackage

/* rtl/core/output_short_circuit_guard.sv */
// output_short_circuit_guard: debounced short-circuit protection with auto retry.
// Depends on oscg_pkg.
`timescale 1ns / 1ps

// Each input transaction is one sample tick: the commanded output level and
// the short-sense level. The block takes one tick per clock cycle while the
// output register drains. All the work for a tick is done in the cycle it is
// accepted and the result is registered in the output register, so the
// sustained rate of one tick per cycle is set only by the output register
// draining (s_tready = output register empty or being taken this cycle).
// The sense line is debounced with saturating low/high run counters; a low
// run of debounce_samples latches a short, which forces the main drive off,
// the complementary pin high and flashes the LED every flash_period_ticks
// ticks. Each stable-high flash event counts the recovery count down; the
// event that finds it already at zero (recovery_periods + 1 stable-high
// events after the last debounced low) clears the short, and the outputs
// follow the command again. Configuration writes are taken at any edge with
// cfg_we high and should only be made while idle.
module output_short_circuit_guard
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [oscg_pkg::CFG_IX_W-1:0]       cfg_index,
    input  logic [oscg_pkg::CFG_W-1:0]          cfg_data,
    // Tick stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [oscg_pkg::TDATA_W-1:0]        s_tdata,   // [0] command_on, [1] sense_low
    // Result stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [oscg_pkg::TDATA_W-1:0]        m_tdata    // [0] led_on, [1] low_side_on,
                                                           // [2] complement_pin, [3] short_active
);

    // Configuration registers
    logic [oscg_pkg::DEB_W-1:0] deb_cfg_reg;
    logic [oscg_pkg::REC_W-1:0] rec_cfg_reg;
    logic [oscg_pkg::PER_W-1:0] per_cfg_reg;

    // Guard state
    logic                       short_reg,   short_next;
    logic [oscg_pkg::REC_W-1:0] rec_reg,     rec_next;
    logic [oscg_pkg::DEB_W-1:0] low_run_reg, low_run_next;
    logic [oscg_pkg::DEB_W-1:0] high_run_reg, high_run_next;
    logic [oscg_pkg::PER_W-1:0] timer_reg,   timer_next;
    logic                       led_reg,     led_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    oscg_pkg::result_t          out_reg,       out_next;

    logic                       accept;
    logic                       cmd;
    logic                       low;
    logic [oscg_pkg::DEB_W-1:0] deb;
    logic [oscg_pkg::PER_W-1:0] per;
    logic                       detect;
    logic                       short_a;
    logic                       led_a;
    logic [oscg_pkg::PER_W-1:0] timer_a;
    logic [oscg_pkg::REC_W-1:0] rec_a;
    logic [oscg_pkg::PER_W:0]   timer_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tdata[0];
    assign low      = s_tdata[1];

    // Zero debounce and flash period settings behave as one
    assign deb = (deb_cfg_reg == '0) ? oscg_pkg::DEB_W'(1) : deb_cfg_reg;
    assign per = (per_cfg_reg == '0) ? oscg_pkg::PER_W'(1) : per_cfg_reg;

    always_comb
    begin
        // Run counters
        if (low)
        begin
            low_run_next  = (low_run_reg < oscg_pkg::RUN_MAX) ? low_run_reg + 1'b1
                                                              : oscg_pkg::RUN_MAX;
            high_run_next = '0;
        end
        else
        begin
            high_run_next = (high_run_reg < oscg_pkg::RUN_MAX) ? high_run_reg + 1'b1
                                                               : oscg_pkg::RUN_MAX;
            low_run_next  = '0;
        end

        // Short detection: reload recovery on every debounced low tick,
        // restart LED and timer only on a fresh latch
        detect  = (low_run_next >= deb);
        short_a = short_reg || detect;
        led_a   = (detect && !short_reg) ? 1'b0 : led_reg;
        timer_a = (detect && !short_reg) ? '0 : timer_reg;
        rec_a   = detect ? rec_cfg_reg : rec_reg;

        timer_inc  = {1'b0, timer_a} + 1'b1;
        short_next = short_a;
        rec_next   = rec_a;
        led_next   = led_a;
        timer_next = '0;

        if (short_a)
        begin
            if (timer_inc >= {1'b0, per})
            begin
                // Flash / recovery check event
                timer_next = '0;
                if (high_run_next >= deb)
                begin
                    if (rec_a != '0)
                    begin
                        rec_next = rec_a - 1'b1;
                        led_next = !led_a;
                    end
                    else
                    begin
                        short_next = 1'b0;
                        led_next   = cmd;
                    end
                end
                else if (low)
                begin
                    rec_next = rec_cfg_reg;
                    led_next = !led_a;
                end
                else
                begin
                    rec_next = rec_cfg_reg;
                end
            end
            else
            begin
                timer_next = timer_inc[oscg_pkg::PER_W-1:0];
            end
        end
        else
        begin
            led_next = cmd;
        end

        // Result from the updated state
        out_next.led_on         = led_next;
        out_next.low_side_on    = short_next ? 1'b0 : cmd;
        out_next.complement_pin = short_next ? 1'b1 : !cmd;
        out_next.short_active   = short_next;

        out_valid_next = accept ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_cfg_reg <= oscg_pkg::DEBOUNCE_RESET;
            rec_cfg_reg <= oscg_pkg::RECOVERY_RESET;
            per_cfg_reg <= oscg_pkg::PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                oscg_pkg::CFG_DEBOUNCE_SAMPLES:
                    deb_cfg_reg <= cfg_data[oscg_pkg::DEB_W-1:0];
                oscg_pkg::CFG_RECOVERY_PERIODS:
                    rec_cfg_reg <= cfg_data[oscg_pkg::REC_W-1:0];
                oscg_pkg::CFG_FLASH_PERIOD_TICKS:
                    per_cfg_reg <= cfg_data[oscg_pkg::PER_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Guard state advances once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg     <= 1'b0;
            rec_reg       <= '0;
            low_run_reg   <= '0;
            high_run_reg  <= '0;
            timer_reg     <= '0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                short_reg    <= short_next;
                rec_reg      <= rec_next;
                low_run_reg  <= low_run_next;
                high_run_reg <= high_run_next;
                timer_reg    <= timer_next;
                led_reg      <= led_next;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(oscg_pkg::TDATA_W - $bits(oscg_pkg::result_t)){1'b0}}, out_reg};

endmodule
